@@ design/tpss_pkg.sv @@
// Shared types, codes and constants for the triangle/plane slice segment block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package tpss_pkg;

  // Exit edge codes carried on the result channel.
  localparam logic [1:0] EDGE_E0     = 2'd0;
  localparam logic [1:0] EDGE_E1     = 2'd1;
  localparam logic [1:0] EDGE_E2     = 2'd2;
  localparam logic [1:0] EDGE_VERTEX = 2'd3;

  // Quotient width and radix-4 step count of the shared divider.
  localparam int QUO_W     = 64;
  localparam int DIV_STEPS = QUO_W / 2;

  // One classified triangle as it travels from the front to the back.
  typedef struct packed {
    logic               hit;
    logic               new_chain;
    logic               vend;
    logic [1:0]         edge_code;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [32:0] dzb;
    logic signed [32:0] dzc;
    logic signed [32:0] dt;
  } entry_t;

endpackage
`default_nettype wire

@@ design/tpss_if.sv @@
// Request channels of the slice segment block: triangles in, segments out.
// Depends on nothing.
`default_nettype none
interface tpss_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert0_x;
  logic signed [31:0] vert0_y;
  logic signed [31:0] vert0_z;
  logic signed [31:0] vert1_x;
  logic signed [31:0] vert1_y;
  logic signed [31:0] vert1_z;
  logic signed [31:0] vert2_x;
  logic signed [31:0] vert2_y;
  logic signed [31:0] vert2_z;
  logic signed [31:0] plane_height;
  logic               new_chain;

  modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, plane_height, new_chain, input ready);
  modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                vert2_x, vert2_y, vert2_z, plane_height, new_chain, output ready);
endinterface

interface tpss_seg_if;
  logic               valid;
  logic               ready;
  logic               seg_valid;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [1:0]         exit_edge;

  modport source (output valid, seg_valid, start_x, start_y, end_x, end_y, exit_edge,
                  input ready);
  modport sink (input valid, seg_valid, start_x, start_y, end_x, end_y, exit_edge,
                output ready);
endinterface
`default_nettype wire

@@ design/tpss_front.sv @@
// Front end: takes triangle requests and sorts them into a crossing case.
// Depends on tpss_pkg and tpss_if.
`default_nettype none
module tpss_front (
  tpss_tri_if.sink         tris,
  input  wire logic        full,
  output tpss_pkg::entry_t entry,
  output logic             push
);

  logic signed [31:0] vx [3];
  logic signed [31:0] vy [3];
  logic signed [31:0] vz [3];
  logic [2:0] lt;
  logic [2:0] gt;
  logic [2:0] eq;
  logic [1:0] ia;
  logic [1:0] ib;
  logic [1:0] ic;

  // A request is taken whenever the queue has room.
  assign tris.ready = !full;
  assign push = tris.valid && !full;

  always_comb begin
    vx[0] = tris.vert0_x; vy[0] = tris.vert0_y; vz[0] = tris.vert0_z;
    vx[1] = tris.vert1_x; vy[1] = tris.vert1_y; vz[1] = tris.vert1_z;
    vx[2] = tris.vert2_x; vy[2] = tris.vert2_y; vz[2] = tris.vert2_z;
  end

  // Compare each vertex height against the plane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lt[i] = vz[i] < tris.plane_height;
      gt[i] = vz[i] > tris.plane_height;
      eq[i] = vz[i] == tris.plane_height;
    end
  end

  // Pick the lone vertex, the start edge vertex and the end edge vertex.
  always_comb begin
    entry = '0;
    ia = 2'd0;
    ib = 2'd0;
    ic = 2'd0;
    entry.new_chain = tris.new_chain;
    entry.hit = 1'b1;
    if (lt[0] && !lt[1] && !lt[2]) begin
      ia = 2'd0; ib = 2'd2; ic = 2'd1; entry.edge_code = tpss_pkg::EDGE_E0;
      entry.vend = eq[1];
    end else if (gt[0] && lt[1] && lt[2]) begin
      ia = 2'd0; ib = 2'd1; ic = 2'd2; entry.edge_code = tpss_pkg::EDGE_E2;
    end else if (lt[1] && !lt[0] && !lt[2]) begin
      ia = 2'd1; ib = 2'd0; ic = 2'd2; entry.edge_code = tpss_pkg::EDGE_E1;
      entry.vend = eq[2];
    end else if (gt[1] && lt[0] && lt[2]) begin
      ia = 2'd1; ib = 2'd2; ic = 2'd0; entry.edge_code = tpss_pkg::EDGE_E0;
    end else if (lt[2] && !lt[1] && !lt[0]) begin
      ia = 2'd2; ib = 2'd1; ic = 2'd0; entry.edge_code = tpss_pkg::EDGE_E2;
      entry.vend = eq[0];
    end else if (gt[2] && lt[1] && lt[0]) begin
      ia = 2'd2; ib = 2'd0; ic = 2'd1; entry.edge_code = tpss_pkg::EDGE_E1;
    end else begin
      entry.hit = 1'b0;
    end
    if (entry.vend) begin
      entry.edge_code = tpss_pkg::EDGE_VERTEX;
    end
    entry.ax = vx[ia];
    entry.ay = vy[ia];
    entry.bx = vx[ib];
    entry.by = vy[ib];
    entry.cx = vx[ic];
    entry.cy = vy[ic];
    entry.dzb = {vz[ib][31], vz[ib]} - {vz[ia][31], vz[ia]};
    entry.dzc = {vz[ic][31], vz[ic]} - {vz[ia][31], vz[ia]};
    entry.dt = {tris.plane_height[31], tris.plane_height} - {vz[ia][31], vz[ia]};
  end

endmodule
`default_nettype wire

@@ design/tpss_fifo.sv @@
// Two-entry queue of classified triangles between the front and the back.
// Depends on tpss_pkg.
`default_nettype none
module tpss_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tpss_pkg::entry_t din,
  input  wire logic             pop,
  output tpss_pkg::entry_t      dout,
  output logic                  full,
  output logic                  empty
);

  tpss_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout = mem[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ design/tpss_div.sv @@
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor, two bits a cycle.
// Depends on tpss_pkg.
`default_nettype none
module tpss_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [63:0]      quotient,
  output logic             done
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] r1;
  logic [32:0] r2;
  logic [31:0] rem_mid;
  logic [31:0] rem_next;
  logic        b1;
  logic        b2;

  // Two restoring steps chained in one cycle.
  always_comb begin
    r1 = {rem, quotient[63]};
    b1 = r1 >= {1'b0, dsr};
    rem_mid = b1 ? 32'(r1 - {1'b0, dsr}) : r1[31:0];
    r2 = {rem_mid, quotient[62]};
    b2 = r2 >= {1'b0, dsr};
    rem_next = b2 ? 32'(r2 - {1'b0, dsr}) : r2[31:0];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      quotient <= {quotient[61:0], b1, b2};
      rem <= rem_next;
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(tpss_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/tpss_back.sv @@
// Back end: interpolates the segment ends of one classified triangle at a time
// with a shared multiplier and divider and holds the result register.
// Depends on tpss_pkg, tpss_if and tpss_div.
`default_nettype none
module tpss_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tpss_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  tpss_seg_if.source            segs
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  tpss_pkg::entry_t cur;
  logic [1:0]  job;
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [31:0] ex;
  logic signed [31:0] ey;
  logic signed [31:0] last_end_x;
  logic signed [31:0] last_end_y;

  // Interpolation operands and registered product.
  logic signed [32:0] dx;
  logic signed [31:0] y0;
  logic signed [31:0] y1;
  logic signed [32:0] dy;
  logic [32:0] mdy_w;
  logic [32:0] mdt_w;
  logic [32:0] mdx_w;
  logic [63:0] prod;
  logic        sgn_diff;
  logic        dxneg;
  logic [31:0] mdx;
  logic signed [31:0] y0_r;
  logic        zdiv;
  logic        qneg;

  // Rounding offset logic.
  logic        nz;
  logic        nneg;
  logic        offneg;
  logic [31:0] half;
  logic [63:0] tmag;
  logic        tneg;

  logic        div_start;
  logic [63:0] quo;
  logic        div_done;
  logic [31:0] qv;
  logic signed [31:0] res;
  logic        seg_ok;
  logic        out_free;
  logic        last_job;

  tpss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tmag),
    .divisor  (mdx),
    .quotient (quo),
    .done     (div_done)
  );

  // Operand selection for the current job: bit 1 picks the end edge, bit 0 picks y.
  always_comb begin
    dx = job[1] ? cur.dzc : cur.dzb;
    y0 = job[0] ? cur.ay : cur.ax;
    if (job[1]) y1 = job[0] ? cur.cy : cur.cx;
    else y1 = job[0] ? cur.by : cur.bx;
    dy = {y1[31], y1} - {y0[31], y0};
    mdy_w = dy[32] ? 33'(-dy) : 33'(dy);
    mdt_w = cur.dt[32] ? 33'(-cur.dt) : 33'(cur.dt);
    mdx_w = dx[32] ? 33'(-dx) : 33'(dx);
  end

  // Signed rounding offset applied to the product.
  always_comb begin
    nz = prod != '0;
    nneg = nz && sgn_diff;
    half = mdx >> 1;
    offneg = (nz && !nneg) ? dxneg : !dxneg;
    if (nneg == offneg) begin
      tmag = prod + {32'd0, half};
      tneg = nneg;
    end else if (prod >= {32'd0, half}) begin
      tmag = prod - {32'd0, half};
      tneg = nneg;
    end else begin
      tmag = {32'd0, half} - prod;
      tneg = offneg;
    end
  end

  assign div_start = (state == S_PREP) && (mdx != '0);
  assign qv = zdiv ? '0 : quo[31:0];
  assign res = qneg ? y0_r - $signed(qv) : y0_r + $signed(qv);
  assign last_job = (job == 2'd3) || ((job == 2'd1) && cur.vend);
  assign out_free = !segs.valid || segs.ready;
  assign seg_ok = cur.hit && !(sx == ex && sy == ey);
  assign pop = (state == S_IDLE) && !empty;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (head.hit && (head.new_chain || !head.vend)) state_next = S_MUL;
          else state_next = S_OUT;
        end
      end
      S_MUL: state_next = S_PREP;
      S_PREP: state_next = S_WAIT;
      S_WAIT: begin
        if (div_done || zdiv) state_next = last_job ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= head;
        job <= head.new_chain ? 2'd0 : 2'd2;
        sx <= last_end_x;
        sy <= last_end_y;
        ex <= head.cx;
        ey <= head.cy;
      end
      S_MUL: begin
        prod <= {32'd0, mdy_w[31:0]} * {32'd0, mdt_w[31:0]};
        sgn_diff <= dy[32] != cur.dt[32];
        dxneg <= dx[32];
        mdx <= mdx_w[31:0];
        y0_r <= y0;
      end
      S_PREP: begin
        zdiv <= mdx == '0;
        qneg <= tneg != dxneg;
      end
      S_WAIT: begin
        if (div_done || zdiv) begin
          case (job)
            2'd0: sx <= res;
            2'd1: sy <= res;
            2'd2: ex <= res;
            default: ey <= res;
          endcase
          job <= job + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Segment chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_end_x <= '0;
      last_end_y <= '0;
    end else if (state == S_OUT && out_free && cur.hit) begin
      last_end_x <= ex;
      last_end_y <= ey;
    end
  end

  // Result register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      segs.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      segs.valid <= 1'b1;
    end else if (segs.ready) begin
      segs.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      segs.seg_valid <= seg_ok;
      segs.start_x <= seg_ok ? sx : '0;
      segs.start_y <= seg_ok ? sy : '0;
      segs.end_x <= seg_ok ? ex : '0;
      segs.end_y <= seg_ok ? ey : '0;
      segs.exit_edge <= seg_ok ? cur.edge_code : tpss_pkg::EDGE_E0;
    end
  end

endmodule
`default_nettype wire

@@ design/triangle_plane_slice_segment_core.sv @@
// Triangle / plane slice segment core.
// Requests on tris carry one triangle, a plane height and a new-chain flag.
// Every accepted request gives exactly one result on segs, in order: a valid
// flag, the segment start and end x,y and the exit edge (3 when the segment
// ends on a vertex lying in the plane). Triangles that miss the plane or give
// a zero-length segment yield a result with seg_valid low and zeroed fields.
// The front classifies a request in the cycle it is taken and places it in a
// two-entry queue, so up to two requests can be taken while the back works.
// The back handles one triangle at a time: each interpolated coordinate goes
// through multiply, round, the shared two-bit-per-cycle divider and store,
// and a triangle needs zero to four of them. With the back idle, a taken
// request passes from the queue through the back's idle state, its steps
// and its output state into the output register. The back starts a new
// triangle only after the last has left; the divider sets the throughput.
// When segs is stalled, the finished result waits in the output register and
// the back holds its next result until that register frees up.
// Synchronous reset empties the queue, drops any result and clears the stored
// end point that a request with new_chain low takes as its start.
// Depends on tpss_pkg, tpss_if, tpss_front, tpss_fifo, tpss_div and tpss_back.
`default_nettype none
module triangle_plane_slice_segment_core (
  input  wire logic  clk,
  input  wire logic  rst,
  tpss_tri_if.sink   tris,
  tpss_seg_if.source segs
);

  tpss_pkg::entry_t front_entry;
  tpss_pkg::entry_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  tpss_front u_front (
    .tris  (tris),
    .full  (full),
    .entry (front_entry),
    .push  (push)
  );

  tpss_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_entry),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  tpss_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .segs  (segs)
  );

endmodule
`default_nettype wire

@@ dv/tpss_tb_if.sv @@
// Holds no testbench copies of the request channels of the slice segment block.
// The block's own interface file lives in design; nothing else is used here.
`timescale 1ns / 1ps

@@ dv/testbench.sv @@
// Testbench for triangle_plane_slice_segment_core: drives triangle requests,
// predicts each segment in its own model and checks results in order.
// Depends on tpss_pkg, tpss_if and the core.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [31:0] vx[3];
    logic signed [31:0] vy[3];
    logic signed [31:0] vz[3];
    logic signed [31:0] height;
    logic               chain;
  } tri_t;

  typedef struct {
    logic        ok;
    logic [31:0] sx, sy, ex, ey;
    logic [1:0]  edge_code;
  } seg_t;

  localparam int WATCHDOG = 4000;

  logic clk = 0;
  logic rst = 1;
  tpss_tri_if tris();
  tpss_seg_if segs();

  triangle_plane_slice_segment_core dut (.clk(clk), .rst(rst), .tris(tris), .segs(segs));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  tri_t        pending[$];
  seg_t        expected_segs[$];
  logic [31:0] chain_x = 0, chain_y = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_gap = 0, recv_gap = 0;
  bit          stim_done = 0;
  bit          hold_send = 0;

  // Rounded linear interpolation in z; +den/2 for a positive numerator, else -den/2.
  function automatic logic signed [31:0] lerp(longint t, longint t0, longint t1,
                                               longint v0, longint v1);
    logic signed [127:0] num, den, q;
    den = t1 - t0;
    if (den == 0) return v0[31:0];
    num = (v1 - v0) * (t - t0);
    if (num > 0) num = num + den / 2;
    else num = num - den / 2;
    q = num / den;
    return 32'(v0 + q);
  endfunction

  // Classify the triangle, build the segment and update the stored end.
  function automatic seg_t slice(tri_t t);
    seg_t   r;
    int     a, b, c, edge_no;
    bit     vend, hit;
    longint z, pz[3];
    logic [31:0] sx, sy, ex, ey;
    r = '{default: 0};
    z = t.height;
    for (int i = 0; i < 3; i++) pz[i] = t.vz[i];
    vend = 0; hit = 1;
    if (pz[0] < z && pz[1] >= z && pz[2] >= z) begin
      a = 0; b = 2; c = 1; edge_no = tpss_pkg::EDGE_E0; vend = pz[1] == z;
    end else if (pz[0] > z && pz[1] < z && pz[2] < z) begin
      a = 0; b = 1; c = 2; edge_no = tpss_pkg::EDGE_E2;
    end else if (pz[1] < z && pz[0] >= z && pz[2] >= z) begin
      a = 1; b = 0; c = 2; edge_no = tpss_pkg::EDGE_E1; vend = pz[2] == z;
    end else if (pz[1] > z && pz[0] < z && pz[2] < z) begin
      a = 1; b = 2; c = 0; edge_no = tpss_pkg::EDGE_E0;
    end else if (pz[2] < z && pz[1] >= z && pz[0] >= z) begin
      a = 2; b = 1; c = 0; edge_no = tpss_pkg::EDGE_E2; vend = pz[0] == z;
    end else if (pz[2] > z && pz[1] < z && pz[0] < z) begin
      a = 2; b = 0; c = 1; edge_no = tpss_pkg::EDGE_E1;
    end else begin
      hit = 0;
    end
    if (!hit) return r;
    if (t.chain) begin
      sx = lerp(z, pz[a], pz[b], t.vx[a], t.vx[b]);
      sy = lerp(z, pz[a], pz[b], t.vy[a], t.vy[b]);
    end else begin
      sx = chain_x;
      sy = chain_y;
    end
    if (vend) begin
      ex = t.vx[c];
      ey = t.vy[c];
      edge_no = tpss_pkg::EDGE_VERTEX;
    end else begin
      ex = lerp(z, pz[a], pz[c], t.vx[a], t.vx[c]);
      ey = lerp(z, pz[a], pz[c], t.vy[a], t.vy[c]);
    end
    chain_x = ex;
    chain_y = ey;
    if (sx == ex && sy == ey) return r;
    r.ok = 1; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.edge_code = 2'(edge_no);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int   span, lone;
    span = $urandom_range(0, 3) == 0 ? 2000000 : 200;
    for (int i = 0; i < 3; i++) begin
      t.vx[i] = rand_coord(span);
      t.vy[i] = rand_coord(span);
      t.vz[i] = rand_coord(span);
    end
    t.height = rand_coord(span);
    t.chain = $urandom_range(0, 2) != 0;
    // Mostly crossing triangles: one vertex on one side, the rest opposite or on it.
    if ($urandom_range(0, 9) < 8) begin
      lone = $urandom_range(0, 2);
      t.height = $signed($urandom_range(0, 2 * span)) - span;
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 5) == 0 && i != lone) t.vz[i] = t.height;
        else if ((i == lone) ^ $urandom_range(0, 1) ^ (i == lone ? 0 : 0)) ;
      end
      t.vz[lone] = t.height - $signed($urandom_range(1, span));
      for (int i = 0; i < 3; i++)
        if (i != lone && t.vz[i] != t.height)
          t.vz[i] = t.height + $signed($urandom_range(1, span));
      if ($urandom_range(0, 1)) begin
        // Mirror so the lone vertex sits above the plane.
        for (int i = 0; i < 3; i++)
          t.vz[i] = 2 * t.height - t.vz[i];
        for (int i = 0; i < 3; i++)
          if (i != lone && t.vz[i] == t.height) t.vz[i] = t.height - 1;
      end
    end
    return t;
  endfunction

  function automatic tri_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                    int x2, int y2, int z2, int h, bit ch);
    tri_t t;
    t.vx = '{x0, x1, x2}; t.vy = '{y0, y1, y2}; t.vz = '{z0, z1, z2};
    t.height = h; t.chain = ch;
    return t;
  endfunction

  // Queue one triangle for the driver.
  task automatic add_tri(tri_t t);
    pending = {pending, t};
  endtask

  // Stimulus.
  initial begin
    int lo, hi;
    lo = 32'h8000_0000; hi = 32'h7fff_ffff;
    add_tri(make_tri(0, 0, -10, 10, 0, 10, 0, 10, 10, 0, 1));
    add_tri(make_tri(0, 0, 10, 10, 0, -10, 0, 10, -10, 0, 1));
    add_tri(make_tri(0, 0, 10, 10, 5, -10, 0, 10, 10, 0, 1));
    add_tri(make_tri(0, 0, -10, 10, 5, 10, 0, 10, -10, 0, 0));
    add_tri(make_tri(0, 0, 10, 10, 5, 10, 7, 10, -10, 0, 1));
    add_tri(make_tri(0, 0, -10, 10, 5, -10, 7, 10, 10, 0, 0));
    add_tri(make_tri(3, 4, -1, 9, 9, 0, 5, 5, 0, 0, 1));
    add_tri(make_tri(3, 4, 0, 9, 9, -1, 5, 5, 0, 0, 1));
    add_tri(make_tri(3, 4, 0, 9, 9, 5, 5, 5, -3, 0, 1));
    add_tri(make_tri(1, 1, 5, 2, 2, 6, 3, 3, 7, 0, 1));
    add_tri(make_tri(1, 1, 0, 2, 2, 0, 3, 3, 0, 0, 1));
    add_tri(make_tri(5, 5, -1, 5, 5, 1, 5, 5, 1, 0, 1));
    add_tri(make_tri(lo, lo, lo, hi, hi, hi, hi, lo, hi, 0, 1));
    add_tri(make_tri(hi, lo, hi, lo, hi, lo, lo, lo, lo, 0, 1));
    add_tri(make_tri(lo, hi, lo, hi, lo, hi, lo, lo, hi, hi, 1));
    add_tri(make_tri(hi, hi, hi, lo, lo, lo, hi, hi, lo, lo + 1, 0));
    add_tri(make_tri(-7, 3, -3, 8, -2, 4, 1, 1, 4, 0, 1));
    add_tri(make_tri(-7, 3, 3, 8, -2, -4, 1, 1, -4, 0, 0));
    repeat (7) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 1200; i++) begin
      if (i == 600) begin
        // Let the block drain completely before going on.
        wait (pending.size() == 0);
        hold_send = 1;
        wait (expected_segs.size() == 0);
        hold_send = 0;
      end
      add_tri(rand_tri());
      if (pending.size() > 8) wait (pending.size() <= 4);
    end
    stim_done = 1;
  end

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      tris.valid <= 0;
    end else begin
      if (tris.valid && tris.ready) begin
        expected_segs = {expected_segs, slice(pending.pop_front())};
        send_gap = pick_gap();
      end
      if ((!tris.valid || tris.ready) && send_gap > 0) send_gap--;
      if (tris.valid && !tris.ready) begin
        // Hold the request.
      end else if (pending.size() > 0 && send_gap == 0 && !hold_send) begin
        tris.valid <= 1;
        tris.vert0_x <= pending[0].vx[0]; tris.vert0_y <= pending[0].vy[0];
        tris.vert0_z <= pending[0].vz[0];
        tris.vert1_x <= pending[0].vx[1]; tris.vert1_y <= pending[0].vy[1];
        tris.vert1_z <= pending[0].vz[1];
        tris.vert2_x <= pending[0].vx[2]; tris.vert2_y <= pending[0].vy[2];
        tris.vert2_z <= pending[0].vz[2];
        tris.plane_height <= pending[0].height;
        tris.new_chain <= pending[0].chain;
      end else begin
        tris.valid <= 0;
      end
    end
  end

  // Monitor: compare each segment with the oldest prediction.
  always @(posedge clk) begin
    seg_t want;
    if (rst) begin
      segs.ready <= 0;
    end else begin
      if (segs.valid && segs.ready) begin
        if (expected_segs.size() == 0) begin
          $error("Unexpected segment result");
          errors++;
        end else begin
          want = expected_segs.pop_front();
          if (segs.seg_valid !== want.ok) begin
            $error("seg_valid: expected %0d, got %0d", want.ok, segs.seg_valid); errors++;
          end
          if (segs.start_x !== want.sx) begin
            $error("start_x: expected %0d, got %0d", $signed(want.sx), segs.start_x);
            errors++;
          end
          if (segs.start_y !== want.sy) begin
            $error("start_y: expected %0d, got %0d", $signed(want.sy), segs.start_y);
            errors++;
          end
          if (segs.end_x !== want.ex) begin
            $error("end_x: expected %0d, got %0d", $signed(want.ex), segs.end_x); errors++;
          end
          if (segs.end_y !== want.ey) begin
            $error("end_y: expected %0d, got %0d", $signed(want.ey), segs.end_y); errors++;
          end
          if (segs.exit_edge !== want.edge_code) begin
            $error("exit_edge: expected %0d, got %0d", want.edge_code, segs.exit_edge);
            errors++;
          end
        end
        recv_gap = pick_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        segs.ready <= 0;
      end else begin
        segs.ready <= 1;
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((tris.valid && tris.ready) || (segs.valid && segs.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done && pending.size() == 0 && !tris.valid && expected_segs.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_segs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/tpss_pkg.sv
design/tpss_if.sv
design/tpss_front.sv
design/tpss_fifo.sv
design/tpss_div.sv
design/tpss_back.sv
design/triangle_plane_slice_segment_core.sv
dv/tpss_tb_if.sv
dv/testbench.sv
